[design/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the duty setpoint smoother.
// ----------------------------------------------------------------------------
package dss_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int DUTY_W   = 10;

	// averaging window, a power of two
	localparam int WINDOW   = 8;
	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int SUM_W    = WIN_BITS + DUTY_W;

	// scaling arithmetic
	localparam int ADC_FULL_SCALE = 4095;
	localparam int DIFF_W  = DUTY_W + 1;
	localparam int PROD_W  = SAMPLE_W + DIFF_W + 1;
	localparam int MAG_W   = SAMPLE_W + DUTY_W;

	// register defaults
	localparam logic [DUTY_W-1:0] DUTY_MIN_RST = DUTY_W'(306);
	localparam logic [DUTY_W-1:0] DUTY_MAX_RST = DUTY_W'(1023);

	// configuration bus
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		REG_DUTY_MIN = 1'b0,
		REG_DUTY_MAX = 1'b1
	} reg_idx_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [DUTY_W-1:0]   duty_t;

	// pipeline advance and item-valid, passed between stages
	typedef struct packed {
		logic adv;
		logic vld;
	} pipe_ctl_t;

endpackage

[design/dss_if.sv]
// ----------------------------------------------------------------------------
// dss_sample_if / dss_duty_if
// Valid/ready channels for ADC samples and smoothed duty results.
// ----------------------------------------------------------------------------
interface dss_sample_if;
	import dss_pkg::*;

	logic    valid;
	logic    ready;
	sample_t adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface dss_duty_if;
	import dss_pkg::*;

	logic  valid;
	logic  ready;
	duty_t duty;

	modport source (output valid, output duty, input ready);
	modport sink (input valid, input duty, output ready);
endinterface

[design/duty_setpoint_smoother.sv]
// ----------------------------------------------------------------------------
// duty_setpoint_smoother
// Scales ADC samples onto the duty range, averages them over a window of
// cells and sends the duty whenever the average changes.
// A sample beat passes the two scaler stages, then the window update
// loads the output register that drives the result beat.
// Throughput: one sample per cycle; a held result stalls the whole pipe.
// Reset clears the window, sum, last duty and valid bits; registers return
// to duty_min 306 and duty_max 1023.
// ----------------------------------------------------------------------------
module duty_setpoint_smoother (
	input  logic                             clk,
	input  logic                             arst_n,
	dss_sample_if.sink                       adc,
	dss_duty_if.source                       setpoint,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dss_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dss_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dss_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import dss_pkg::*;

	duty_t     duty_min_q;
	duty_t     duty_max_q;
	reg_idx_t  reg_idx;
	logic      adv;
	pipe_ctl_t ctl_in;
	pipe_ctl_t ctl_win;
	duty_t     scaled;
	logic      emit;
	duty_t     avg;
	logic      res_vld_q;
	duty_t     res_duty_q;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_min_q <= DUTY_MIN_RST;
			duty_max_q <= DUTY_MAX_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_DUTY_MIN: duty_min_q <= pwdata[DUTY_W-1:0];
				REG_DUTY_MAX: duty_max_q <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DUTY_MIN: prdata = APB_DATA_W'(duty_min_q);
			REG_DUTY_MAX: prdata = APB_DATA_W'(duty_max_q);
			default:      prdata = '0;
		endcase
	end

	// pipe advances unless a result beat is held
	assign adv       = !res_vld_q || setpoint.ready;
	assign adc.ready = adv;
	assign ctl_in.adv = adv;
	assign ctl_in.vld = adc.valid;

	dss_scaler u_scaler (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_in),
		.sample  (adc.adc_sample),
		.duty_min(duty_min_q),
		.duty_max(duty_max_q),
		.ctl_out (ctl_win),
		.scaled  (scaled)
	);

	dss_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_win),
		.scaled(scaled),
		.emit  (emit),
		.avg   (avg)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit) begin
			res_vld_q <= 1'b1;
		end else if (setpoint.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_duty_q <= avg;
		end
	end

	assign setpoint.valid = res_vld_q;
	assign setpoint.duty  = res_duty_q;

endmodule

[design/dss_scaler.sv]
// ----------------------------------------------------------------------------
// dss_scaler
// Two-stage linear map of a 12-bit sample onto the duty range.
// ----------------------------------------------------------------------------
module dss_scaler (
	input  logic               clk,
	input  logic               arst_n,
	input  dss_pkg::pipe_ctl_t ctl_in,
	input  dss_pkg::sample_t   sample,
	input  dss_pkg::duty_t     duty_min,
	input  dss_pkg::duty_t     duty_max,
	output dss_pkg::pipe_ctl_t ctl_out,
	output dss_pkg::duty_t     scaled
);
	import dss_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     vld_s2;
	duty_t                    scaled_s2;

	logic                     neg;
	logic [PROD_W-1:0]        mag_full;
	logic [MAG_W-1:0]         mag;
	logic [DUTY_W-1:0]        hi_part;
	logic [SAMPLE_W-1:0]      lo_part;
	logic [SAMPLE_W:0]        fold;
	logic [DUTY_W:0]          quot;
	logic signed [DUTY_W+1:0] quot_s;
	logic signed [DUTY_W+1:0] val;

	// stage 1: signed product sample * (max - min)
	assign diff = $signed({1'b0, duty_max}) - $signed({1'b0, duty_min});
	assign prod = $signed({1'b0, sample}) * diff;

	// stage 2: divide magnitude by 4095, p = 4096a + b = 4095a + (a + b)
	assign neg      = prod_s1[PROD_W-1];
	assign mag_full = neg ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	assign mag      = mag_full[MAG_W-1:0];
	assign hi_part  = mag[MAG_W-1:SAMPLE_W];
	assign lo_part  = mag[SAMPLE_W-1:0];
	assign fold     = {3'b000, hi_part} + {1'b0, lo_part};
	assign quot     = {1'b0, hi_part}
		+ {{DUTY_W{1'b0}}, (fold >= (SAMPLE_W+1)'(ADC_FULL_SCALE))};
	assign quot_s   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign val      = $signed({2'b00, duty_min}) + quot_s;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ctl_in.adv) begin
			vld_s1 <= ctl_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl_in.adv) begin
			prod_s1   <= prod;
			scaled_s2 <= val[DUTY_W-1:0];
		end
	end

	assign ctl_out.adv = ctl_in.adv;
	assign ctl_out.vld = vld_s2;
	assign scaled      = scaled_s2;

endmodule

[design/dss_cell.sv]
// ----------------------------------------------------------------------------
// dss_cell
// One window entry; takes the value on din on every shift.
// ----------------------------------------------------------------------------
module dss_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  dss_pkg::duty_t din,
	output dss_pkg::duty_t dout
);
	import dss_pkg::*;

	duty_t entry_q;

	// entry register, cleared so the average ramps up from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

[design/dss_window.sv]
// ----------------------------------------------------------------------------
// dss_window
// Row of window cells, running sum and change detection on the average.
// ----------------------------------------------------------------------------
module dss_window (
	input  logic               clk,
	input  logic               arst_n,
	input  dss_pkg::pipe_ctl_t ctl,
	input  dss_pkg::duty_t     scaled,
	output logic               emit,
	output dss_pkg::duty_t     avg
);
	import dss_pkg::*;

	logic              load;
	duty_t             entry [WINDOW];
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	duty_t             last_duty_q;
	logic [SUM_W-1:0]  cell_sum;

	assign load = ctl.adv & ctl.vld;

	// chain of cells, oldest entry at the far end
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			dss_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (load),
				.din   (scaled),
				.dout  (entry[i])
			);
		end else begin : g_body
			dss_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (load),
				.din   (entry[i-1]),
				.dout  (entry[i])
			);
		end
	end

	// running sum: drop oldest, add newest
	assign sum_next = sum_q - SUM_W'(entry[WINDOW-1]) + SUM_W'(scaled);
	assign avg      = sum_next[SUM_W-1:WIN_BITS];
	assign emit     = load & (avg != last_duty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			last_duty_q <= '0;
		end else begin
			if (load) begin
				sum_q <= sum_next;
			end
			if (emit) begin
				last_duty_q <= avg;
			end
		end
	end

	// sum of all cells, for checking only
	always_comb begin
		cell_sum = '0;
		for (int k = 0; k < WINDOW; k++) begin
			cell_sum = cell_sum + SUM_W'(entry[k]);
		end
	end

	a_sum_matches: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q == cell_sum)
		else $error("running sum out of step with window cells");

	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> last_duty_q == $past(avg))
		else $error("last duty not updated on emitted beat");

	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> $stable(last_duty_q))
		else $error("last duty changed without a beat");

endmodule
